@@ rtl/effect_handler_evidence_stack_unit_defines.svh @@
// Assertion macros shared by the evidence stack RTL.
`ifndef EFFECT_HANDLER_EVIDENCE_STACK_UNIT_DEFINES_SVH
`define EFFECT_HANDLER_EVIDENCE_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EHES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EHES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ehes_pkg.sv @@
// Types and constants shared by the evidence stack modules.
package ehes_pkg;

  localparam int LBL_W  = 32;
  localparam int HID_W  = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_MASK     = 3'd1,
    OP_SUPPRESS = 3'd2,
    OP_REBIND   = 3'd3,
    OP_NAMES    = 3'd4,
    OP_LOOKUP   = 3'd5,
    OP_CLEAR    = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    RS_DONE = 3'd0,
    RS_LIVE = 3'd1,
    RS_SUPP = 3'd2,
    RS_MISS = 3'd3,
    RS_FULL = 3'd4
  } res_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             supp;
    logic [HID_W-1:0] hid;
    logic [LBL_W-1:0] lbl;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic shift;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic hit;
    logic walk_end;
  } dp_sts_t;

endpackage

@@ rtl/ehes_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ehes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/ehes_ctrl.sv @@
// Controller state machine that sequences one stack operation at a time.
module ehes_ctrl
  import ehes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_MASK, OP_SUPPRESS, OP_REBIND, OP_NAMES, OP_LOOKUP: begin
            state_nxt = sts.empty ? S_FIN : S_SCAN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.op == OP_MASK) begin
            state_nxt = S_SHIFT;
          end else if (sts.op != OP_REBIND) begin
            state_nxt = S_FIN;
          end
        end else if (sts.walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_SHIFT: begin
        if (sts.walk_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.exec   = (state_r == S_EXEC);
    cmd.scan   = (state_r == S_SCAN);
    cmd.shift  = (state_r == S_SHIFT);
    cmd.finish = (state_r == S_FIN) && (!out_valid_r || !out_stall);
    in_stall   = (state_r != S_IDLE);
    out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/ehes_dp.sv @@
// Datapath: entry memory, walk pointers, match logic and result registers.
module ehes_dp
  import ehes_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output dp_sts_t           sts,
  input  logic [OP_W-1:0]   in_op,
  input  logic [LBL_W-1:0]  in_label,
  input  logic [HID_W-1:0]  in_handler_id,
  input  logic [HID_W-1:0]  in_new_handler_id,
  output logic [STAT_W-1:0] out_status,
  output logic [HID_W-1:0]  out_found_handler,
  output logic [CNT_W-1:0]  out_entry_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t              op_r, op_nxt;
  logic [LBL_W-1:0] label_r, label_nxt;
  logic [HID_W-1:0] hid_r, hid_nxt;
  logic [HID_W-1:0] nhid_r, nhid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             dval_r, dval_nxt;
  logic [IW-1:0]    daddr_r, daddr_nxt;
  res_status_t      res_status_r, res_status_nxt;
  logic [HID_W-1:0] res_found_r, res_found_nxt;
  res_status_t      out_status_r, out_status_nxt;
  logic [HID_W-1:0] out_found_r, out_found_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  entry_t           rd_data;
  logic             dir_down;
  logic             lbl_eq;
  logic             hid_eq;
  logic             hit;
  logic             full;

  ehes_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    dir_down = cmd.scan && ((op_r == OP_MASK) || (op_r == OP_LOOKUP));
    rd_en    = (cmd.scan || cmd.shift) && (rem_r != '0);
    lbl_eq   = (rd_data.lbl == label_r);
    hid_eq   = (rd_data.hid == hid_r);
    full     = (count_r == CW'(DEPTH));
    if ((op_r == OP_MASK) || (op_r == OP_LOOKUP)) begin
      hit = dval_r && lbl_eq;
    end else begin
      hit = dval_r && hid_eq;
    end
  end

  always_comb begin
    op_nxt         = op_r;
    label_nxt      = label_r;
    hid_nxt        = hid_r;
    nhid_nxt       = nhid_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    dval_nxt       = dval_r;
    daddr_nxt      = daddr_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = daddr_r;
    wr_data        = rd_data;

    if (cmd.load) begin
      op_nxt         = op_t'(in_op);
      label_nxt      = in_label;
      hid_nxt        = in_handler_id;
      nhid_nxt       = in_new_handler_id;
      res_status_nxt = RS_MISS;
      res_found_nxt  = '0;
    end

    if (cmd.exec) begin
      if ((op_r == OP_MASK) || (op_r == OP_LOOKUP)) begin
        ptr_nxt = IW'(count_r - CW'(1));
      end else begin
        ptr_nxt = '0;
      end
      rem_nxt  = count_r;
      dval_nxt = 1'b0;
      case (op_r)
        OP_PUSH: begin
          if (full) begin
            res_status_nxt = RS_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = count_r[IW-1:0];
            wr_data.supp   = 1'b0;
            wr_data.hid    = hid_r;
            wr_data.lbl    = label_r;
            count_nxt      = count_r + CW'(1);
            res_status_nxt = RS_DONE;
          end
        end
        OP_CLEAR: begin
          count_nxt      = '0;
          res_status_nxt = RS_DONE;
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan || cmd.shift) begin
      dval_nxt = rd_en;
      if (rd_en) begin
        ptr_nxt   = dir_down ? (ptr_r - IW'(1)) : (ptr_r + IW'(1));
        rem_nxt   = rem_r - CW'(1);
        daddr_nxt = ptr_r;
      end
    end

    if (cmd.scan && hit) begin
      case (op_r)
        OP_MASK: begin
          // Innermost match found: move the entries above it down by one.
          res_status_nxt = RS_DONE;
          count_nxt      = count_r - CW'(1);
          ptr_nxt        = daddr_r + IW'(1);
          rem_nxt        = count_r - CW'(1) - CW'(daddr_r);
          dval_nxt       = 1'b0;
        end
        OP_SUPPRESS: begin
          wr_en          = 1'b1;
          wr_data.supp   = 1'b1;
          res_status_nxt = RS_DONE;
        end
        OP_REBIND: begin
          wr_en          = 1'b1;
          wr_data.hid    = nhid_r;
          res_status_nxt = RS_DONE;
        end
        OP_NAMES: begin
          res_status_nxt = RS_LIVE;
        end
        OP_LOOKUP: begin
          res_status_nxt = rd_data.supp ? RS_SUPP : RS_LIVE;
          res_found_nxt  = rd_data.hid;
        end
        default: begin
        end
      endcase
    end

    if (cmd.shift && dval_r) begin
      wr_en   = 1'b1;
      wr_addr = daddr_r - IW'(1);
    end

    if (cmd.finish) begin
      out_status_nxt = res_status_r;
      out_found_nxt  = res_found_r;
      out_count_nxt  = CNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r   <= '0;
      dval_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      dval_r  <= dval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    label_r      <= label_nxt;
    hid_r        <= hid_nxt;
    nhid_r       <= nhid_nxt;
    ptr_r        <= ptr_nxt;
    daddr_r      <= daddr_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    sts.op       = op_r;
    sts.empty    = (count_r == '0);
    sts.hit      = hit;
    sts.walk_end = !dval_r && (rem_r == '0);
  end

  assign out_status        = out_status_r;
  assign out_found_handler = out_found_r;
  assign out_entry_count   = out_count_r;

endmodule

@@ rtl/effect_handler_evidence_stack_unit.sv @@
// Push, clear and unknown codes pass through the EXEC and FIN states before the result beat.
// Scans read the entry RAM one entry per cycle.
// Mask adds a shift pass after a hit, which moves the entries above the match down by one.
// One beat is in flight at a time; the next is taken as the result beat appears.
// Reset (rst_n low, synchronous) empties the stack.
`include "effect_handler_evidence_stack_unit_defines.svh"

// Top level of the effect handler evidence stack.
module effect_handler_evidence_stack_unit
  import ehes_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [LBL_W-1:0]  in_label,
  input  logic [HID_W-1:0]  in_handler_id,
  input  logic [HID_W-1:0]  in_new_handler_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [HID_W-1:0]  out_found_handler,
  output logic [CNT_W-1:0]  out_entry_count
);

  // The controller only sequences; every entry access, match and result
  // register lives in the datapath. They talk through one command struct
  // and one status struct.
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ehes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the stack in a single RAM of packed entries. A walk
  // issues one read per cycle and checks the data in the following cycle, so a
  // rebind can write back behind the read pointer without a conflict, and a
  // mask shift copies entry k+1 into k while the next entry is being read.
  ehes_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_label          (in_label),
    .in_handler_id     (in_handler_id),
    .in_new_handler_id (in_new_handler_id),
    .out_status        (out_status),
    .out_found_handler (out_found_handler),
    .out_entry_count   (out_entry_count)
  );

  // Handshake and result conditions that the checks below are written on.
  logic in_take;
  logic full_beat;
  logic cnt_at_depth;
  logic plain_beat;

  assign in_take      = in_valid && !in_stall;
  assign full_beat    = out_valid && (out_status == RS_FULL);
  assign cnt_at_depth = (out_entry_count == CNT_W'(DEPTH));
  assign plain_beat   = out_valid && (out_status != RS_LIVE) && (out_status != RS_SUPP);

  // After an input beat is taken the block is busy in the next cycle.
  `EHES_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "accept not followed by busy")

  // A full result can only come from a stack holding DEPTH entries.
  `EHES_ASSERT_NOW(a_full_count, full_beat, cnt_at_depth, "full status with short stack")

  // Only a lookup hit reports a handler id.
  `EHES_ASSERT_NOW(a_found_zero, plain_beat, out_found_handler == '0, "handler id without a hit")

endmodule
